FILE: sv/vns_pkg.sv
// ----------------------------------------------------------------------------
// vns_pkg
// shared types and constants for the nearest-site pixel classifier
// ----------------------------------------------------------------------------
package vns_pkg;

	localparam int MAX_SITES    = 128;
	localparam int COORD_BITS   = 12;
	localparam int IDX_W        = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
	localparam int CNT_W        = $clog2(MAX_SITES + 1);
	localparam int SQ_W         = 2 * COORD_BITS;
	localparam int DIST_W       = 2 * COORD_BITS + 1;
	localparam int CHAN_W       = 8;
	localparam int COLOR_W      = 3 * CHAN_W;
	localparam int STATUS_W     = 3;
	localparam int SITE_INDEX_W = 7;
	localparam int REG_W        = 13;
	localparam int CFG_IDX_W    = 2;

	localparam logic [REG_W-1:0]   RESET_WIDTH  = REG_W'(800);
	localparam logic [REG_W-1:0]   RESET_HEIGHT = REG_W'(400);
	localparam logic [CHAN_W-1:0]  BG_LEVEL     = CHAN_W'(255);
	localparam logic [COLOR_W-1:0] BG_COLOR     = {BG_LEVEL, BG_LEVEL, BG_LEVEL};
	localparam logic [DIST_W-1:0]  DIST_MAX     = '1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic {
		KIND_ADD      = 1'b0,
		KIND_CLASSIFY = 1'b1
	} kind_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_CLASSIFIED = 3'd0,
		ST_ADDED      = 3'd1,
		ST_FULL       = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_OUTSIDE    = 3'd4
	} status_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RASTER_WIDTH  = 2'd0,
		CFG_RASTER_HEIGHT = 2'd1
	} cfg_reg_e;

	// one transaction travelling down the cell row
	typedef struct packed {
		status_e                 status;
		cnt_t                    cnt;
		logic [COORD_BITS-1:0]   px;
		logic [COORD_BITS-1:0]   py;
		idx_t                    idx;
		logic [COLOR_W-1:0]      color;
		logic [DIST_W-1:0]       near_sq;
	} tok_t;

endpackage

FILE: sv/vns_ifs.sv
// ----------------------------------------------------------------------------
// vns_ifs
// valid/ready channels of the nearest-site pixel classifier
// ----------------------------------------------------------------------------
interface vns_item_if;
	import vns_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [CHAN_W-1:0]     red_in;
	logic [CHAN_W-1:0]     green_in;
	logic [CHAN_W-1:0]     blue_in;

	modport source (output valid, kind, pos_x, pos_y, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, kind, pos_x, pos_y, red_in, green_in, blue_in,
		output ready);
endinterface

interface vns_result_if;
	import vns_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic [SITE_INDEX_W-1:0] site_index;
	logic [CHAN_W-1:0]       red_out;
	logic [CHAN_W-1:0]       green_out;
	logic [CHAN_W-1:0]       blue_out;

	modport source (output valid, status, site_index, red_out, green_out, blue_out,
		input ready);
	modport sink (input valid, status, site_index, red_out, green_out, blue_out,
		output ready);
endinterface

interface vns_cfg_if;
	import vns_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [REG_W-1:0]     wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: sv/vns_cell.sv
// ----------------------------------------------------------------------------
// vns_cell
// one site cell: holds a site, squares the offsets, keeps the nearer site
// ----------------------------------------------------------------------------
module vns_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  vns_pkg::idx_t cell_id,
	input  logic          vld_in,
	input  vns_pkg::tok_t tok_in,
	output logic          vld_out,
	output vns_pkg::tok_t tok_out
);
	import vns_pkg::*;

	logic [COORD_BITS-1:0] site_x_q;
	logic [COORD_BITS-1:0] site_y_q;
	logic [COLOR_W-1:0]    site_color_q;

	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic                  wr_site;

	logic               vld_s1;
	tok_t               tok_s1;
	logic [SQ_W-1:0]    sq_x_s1;
	logic [SQ_W-1:0]    sq_y_s1;
	logic               hit_s1;
	logic [COLOR_W-1:0] col_s1;

	logic [DIST_W-1:0] dist_sum;
	tok_t              tok_upd;

	logic vld_s2;
	tok_t tok_s2;

	assign wr_site = en && vld_in && (tok_in.status == ST_ADDED) && (tok_in.idx == cell_id);
	assign dx = (tok_in.px > site_x_q) ? (tok_in.px - site_x_q) : (site_x_q - tok_in.px);
	assign dy = (tok_in.py > site_y_q) ? (tok_in.py - site_y_q) : (site_y_q - tok_in.py);

	always_ff @(posedge clk) begin
		if (wr_site) begin
			site_x_q     <= tok_in.px;
			site_y_q     <= tok_in.py;
			site_color_q <= tok_in.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s1  <= tok_in;
			sq_x_s1 <= SQ_W'(dx) * SQ_W'(dx);
			sq_y_s1 <= SQ_W'(dy) * SQ_W'(dy);
			hit_s1  <= (tok_in.status == ST_CLASSIFIED) && (CNT_W'(cell_id) < tok_in.cnt);
			col_s1  <= site_color_q;
			tok_s2  <= tok_upd;
		end
	end

	always_comb begin
		dist_sum = DIST_W'(sq_x_s1) + DIST_W'(sq_y_s1);
		tok_upd  = tok_s1;
		if (hit_s1 && (dist_sum < tok_s1.near_sq)) begin
			tok_upd.near_sq = dist_sum;
			tok_upd.idx     = cell_id;
			tok_upd.color   = col_s1;
		end
	end

	assign vld_out = vld_s2;
	assign tok_out = tok_s2;

endmodule

FILE: sv/voronoi_nearest_site_pixel_core.sv
// ----------------------------------------------------------------------------
// voronoi_nearest_site_pixel_core
// nearest-site pixel classifier built as a row of site cells
// ----------------------------------------------------------------------------
// Every transaction, site add or pixel classify, enters a row of MAX_SITES
// cells and moves one stage per clock while the row is not stalled; each
// cell is two stages (offset squares, then add and compare). A new
// transaction is accepted every cycle unless the row is stalled; the cell row
// and the single output register stall together only while a finished result
// is not taken. An add writes its cell as it passes, so every later pixel
// sees it and earlier pixels do not. The raster registers are written through
// the cfg channel, which is always ready.
module voronoi_nearest_site_pixel_core (
	input  logic clk,
	input  logic arst_n,
	vns_item_if.sink     item,
	vns_result_if.source result,
	vns_cfg_if.sink      cfg
);
	import vns_pkg::*;

	logic [REG_W-1:0] raster_width_q;
	logic [REG_W-1:0] raster_height_q;
	cnt_t             count_q;

	logic en;
	logic item_acc;
	logic is_add;
	logic full;
	logic outside;
	tok_t tok_entry;

	logic vld_c [MAX_SITES+1];
	tok_t tok_c [MAX_SITES+1];

	logic res_valid_q;
	tok_t res_q;

	logic [IDX_W+SITE_INDEX_W-1:0] idx_ext;

	// config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_width_q  <= RESET_WIDTH;
			raster_height_q <= RESET_HEIGHT;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				CFG_RASTER_WIDTH:  raster_width_q  <= cfg.wdata;
				CFG_RASTER_HEIGHT: raster_height_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// entry: decide status and build the transaction
	assign en         = !(vld_c[MAX_SITES] && res_valid_q && !result.ready);
	assign item.ready = en;
	assign item_acc   = item.valid && en;
	assign is_add     = (item.kind == KIND_ADD);
	assign full       = (count_q >= CNT_W'(MAX_SITES));
	assign outside    = (REG_W'(item.pos_x) >= raster_width_q) ||
		(REG_W'(item.pos_y) >= raster_height_q);

	always_comb begin
		tok_entry.cnt     = count_q;
		tok_entry.px      = item.pos_x;
		tok_entry.py      = item.pos_y;
		tok_entry.near_sq = DIST_MAX;
		tok_entry.idx     = '0;
		tok_entry.color   = '0;
		if (is_add) begin
			if (full) begin
				tok_entry.status = ST_FULL;
			end else begin
				tok_entry.status = ST_ADDED;
				tok_entry.idx    = count_q[IDX_W-1:0];
				tok_entry.color  = {item.red_in, item.green_in, item.blue_in};
			end
		end else if (outside) begin
			tok_entry.status = ST_OUTSIDE;
			tok_entry.color  = BG_COLOR;
		end else if (count_q == '0) begin
			tok_entry.status = ST_EMPTY;
			tok_entry.color  = BG_COLOR;
		end else begin
			tok_entry.status = ST_CLASSIFIED;
		end
	end

	assign vld_c[0] = item_acc;
	assign tok_c[0] = tok_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (item_acc && is_add && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// cell row
	for (genvar g = 0; g < MAX_SITES; g++) begin : g_cell
		vns_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.cell_id (IDX_W'(g)),
			.vld_in  (vld_c[g]),
			.tok_in  (tok_c[g]),
			.vld_out (vld_c[g+1]),
			.tok_out (tok_c[g+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en && vld_c[MAX_SITES]) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_c[MAX_SITES]) begin
			res_q <= tok_c[MAX_SITES];
		end
	end

	assign idx_ext           = {{SITE_INDEX_W{1'b0}}, res_q.idx};
	assign result.valid      = res_valid_q;
	assign result.status     = res_q.status;
	assign result.site_index = idx_ext[SITE_INDEX_W-1:0];
	assign result.red_out    = res_q.color[3*CHAN_W-1:2*CHAN_W];
	assign result.green_out  = res_q.color[2*CHAN_W-1:CHAN_W];
	assign result.blue_out   = res_q.color[CHAN_W-1:0];

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SITES))
		else $error("site count beyond table size");

	a_stall_blocks_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_c[MAX_SITES] && res_valid_q && !result.ready) |-> !item.ready)
		else $error("entry open while row is stalled");

	a_full_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && is_add && full) |=> $stable(count_q))
		else $error("dropped add changed site count");

	a_classified_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_CLASSIFIED) |-> (CNT_W'(res_q.idx) < count_q))
		else $error("nearest site index not a written site");

endmodule

FILE: dv/voronoi_nearest_site_pixel_core_tb.sv
// ----------------------------------------------------------------------------
// voronoi_nearest_site_pixel_core_tb
// self-checking bench for the nearest-site pixel classifier
// ----------------------------------------------------------------------------
// A short table of site adds and pixel lookups runs at reset raster size. It
// is followed by random traffic in six segments, each with its own raster
// setting: full size, one pixel, zero, random, reset size and the widest
// register values. Every accepted transaction goes through a local model of
// the site table. Each result is compared field by field, in order, against
// the oldest expected one. Both channels stall at random, and the table is
// filled past capacity along the way.
// ----------------------------------------------------------------------------
module voronoi_nearest_site_pixel_core_tb;
	import vns_pkg::*;

	localparam int LATENCY     = 2 * MAX_SITES + 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SEG_ITEMS   = 75;
	localparam int SEG_COUNT   = 6;
	localparam int SEG_RANDOM  = 3;
	localparam int COORD_SPAN  = 1 << COORD_BITS;
	localparam int DIR_N       = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic [REG_W-1:0] SEG_WIDTH [SEG_COUNT] =
		'{13'd4096, 13'd1, 13'd0, 13'd0, 13'd800, 13'd8191};
	localparam logic [REG_W-1:0] SEG_HEIGHT [SEG_COUNT] =
		'{13'd4096, 13'd1, 13'd0, 13'd0, 13'd400, 13'd8191};

	typedef struct packed {
		kind_e                 kind;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [CHAN_W-1:0]     r;
		logic [CHAN_W-1:0]     g;
		logic [CHAN_W-1:0]     b;
	} pixel_item_t;

	typedef struct packed {
		status_e                 status;
		logic [SITE_INDEX_W-1:0] idx;
		logic [CHAN_W-1:0]       r;
		logic [CHAN_W-1:0]       g;
		logic [CHAN_W-1:0]       b;
	} site_result_t;

	typedef struct packed {
		pixel_item_t  it;
		logic         typed;
		site_result_t res;
	} dir_row_t;

	// typed rows carry a hand-written expected result
	dir_row_t dir_rows [DIR_N] = '{
		'{'{KIND_CLASSIFY, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{ST_EMPTY, 7'd0, BG_LEVEL, BG_LEVEL, BG_LEVEL}},
		'{'{KIND_CLASSIFY, 12'd800, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{ST_OUTSIDE, 7'd0, BG_LEVEL, BG_LEVEL, BG_LEVEL}},
		'{'{KIND_CLASSIFY, 12'd0, 12'd400, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{ST_OUTSIDE, 7'd0, BG_LEVEL, BG_LEVEL, BG_LEVEL}},
		'{'{KIND_CLASSIFY, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
			'{ST_OUTSIDE, 7'd0, BG_LEVEL, BG_LEVEL, BG_LEVEL}},
		'{'{KIND_CLASSIFY, 12'd799, 12'd399, 8'h5A, 8'hA5, 8'h3C}, 1'b1,
			'{ST_EMPTY, 7'd0, BG_LEVEL, BG_LEVEL, BG_LEVEL}},
		'{'{KIND_ADD, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{ST_ADDED, 7'd0, 8'h00, 8'h00, 8'h00}},
		'{'{KIND_ADD, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
			'{ST_ADDED, 7'd1, 8'hFF, 8'hFF, 8'hFF}},
		'{'{KIND_ADD, 12'd799, 12'd399, 8'hAA, 8'h55, 8'hC3}, 1'b1,
			'{ST_ADDED, 7'd2, 8'hAA, 8'h55, 8'hC3}},
		'{'{KIND_CLASSIFY, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{KIND_CLASSIFY, 12'd799, 12'd399, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{KIND_CLASSIFY, 12'd400, 12'd200, 8'hFF, 8'h00, 8'hFF}, 1'b0, '0},
		'{'{KIND_ADD, 12'd10, 12'd0, 8'h12, 8'h34, 8'h56}, 1'b1,
			'{ST_ADDED, 7'd3, 8'h12, 8'h34, 8'h56}},
		'{'{KIND_CLASSIFY, 12'd5, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{KIND_ADD, 12'd0, 12'd0, 8'h0F, 8'hF0, 8'h5A}, 1'b1,
			'{ST_ADDED, 7'd4, 8'h0F, 8'hF0, 8'h5A}},
		'{'{KIND_CLASSIFY, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{KIND_CLASSIFY, 12'd799, 12'd0, 8'h81, 8'h42, 8'h24}, 1'b0, '0},
		'{'{KIND_ADD, 12'd2048, 12'd1024, 8'h80, 8'h01, 8'h7F}, 1'b1,
			'{ST_ADDED, 7'd5, 8'h80, 8'h01, 8'h7F}},
		'{'{KIND_CLASSIFY, 12'd798, 12'd399, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{KIND_CLASSIFY, 12'd0, 12'd399, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
		'{'{KIND_CLASSIFY, 12'd799, 12'd400, 8'h00, 8'h00, 8'h00}, 1'b1,
			'{ST_OUTSIDE, 7'd0, BG_LEVEL, BG_LEVEL, BG_LEVEL}}
	};

	logic clk;
	logic arst_n;

	vns_item_if   item_ch ();
	vns_result_if result_ch ();
	vns_cfg_if    cfg_ch ();

	voronoi_nearest_site_pixel_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// local copy of the site table and raster
	logic [COORD_BITS-1:0] site_x     [MAX_SITES];
	logic [COORD_BITS-1:0] site_y     [MAX_SITES];
	logic [COLOR_W-1:0]    site_color [MAX_SITES];
	int                    site_total;
	logic [REG_W-1:0]      raster_w;
	logic [REG_W-1:0]      raster_h;

	site_result_t nearest_queue [$];
	site_result_t want;
	int           error_count;
	int           cycle_count;
	int           src_idle_pct;
	int           sink_idle_pct;

	function automatic site_result_t classify_and_update(input pixel_item_t it);
		site_result_t r;
		int           px;
		int           py;
		int           dx;
		int           dy;
		int           d;
		int           best;
		int           best_d;
		logic [COLOR_W-1:0] c;
		px = int'(it.x);
		py = int'(it.y);
		if (it.kind == KIND_ADD) begin
			if (site_total >= MAX_SITES) begin
				r = '{ST_FULL, '0, '0, '0, '0};
			end else begin
				site_x[site_total]     = it.x;
				site_y[site_total]     = it.y;
				site_color[site_total] = {it.r, it.g, it.b};
				r = '{ST_ADDED, SITE_INDEX_W'(site_total), it.r, it.g, it.b};
				site_total++;
			end
		end else if (it.x >= raster_w || it.y >= raster_h) begin
			r = '{ST_OUTSIDE, '0, BG_LEVEL, BG_LEVEL, BG_LEVEL};
		end else if (site_total == 0) begin
			r = '{ST_EMPTY, '0, BG_LEVEL, BG_LEVEL, BG_LEVEL};
		end else begin
			best   = 0;
			best_d = -1;
			for (int i = 0; i < site_total; i++) begin
				dx = px - int'(site_x[i]);
				dy = py - int'(site_y[i]);
				d  = dx * dx + dy * dy;
				// strict compare keeps the lowest index on a tie
				if (best_d < 0 || d < best_d) begin
					best_d = d;
					best   = i;
				end
			end
			c = site_color[best];
			r = '{ST_CLASSIFIED, SITE_INDEX_W'(best), c[23:16], c[15:8], c[7:0]};
		end
		return r;
	endfunction

	function automatic pixel_item_t make_random_item();
		pixel_item_t it;
		int          lim_x;
		int          lim_y;
		int          sel;
		it.r  = CHAN_W'($urandom);
		it.g  = CHAN_W'($urandom);
		it.b  = CHAN_W'($urandom);
		sel   = $urandom_range(0, 99);
		lim_x = (int'(raster_w) > COORD_SPAN) ? COORD_SPAN : int'(raster_w);
		lim_y = (int'(raster_h) > COORD_SPAN) ? COORD_SPAN : int'(raster_h);
		if ($urandom_range(0, 99) < 45) begin
			it.kind = KIND_ADD;
			if (sel < 25) begin
				it.x = COORD_BITS'($urandom_range(0, 15));
				it.y = COORD_BITS'($urandom_range(0, 15));
			end else begin
				it.x = COORD_BITS'($urandom_range(0, COORD_SPAN - 1));
				it.y = COORD_BITS'($urandom_range(0, COORD_SPAN - 1));
			end
		end else begin
			it.kind = KIND_CLASSIFY;
			if (sel < 70 && lim_x > 0 && lim_y > 0) begin
				it.x = COORD_BITS'($urandom_range(0, lim_x - 1));
				it.y = COORD_BITS'($urandom_range(0, lim_y - 1));
			end else if (sel < 90) begin
				it.x = COORD_BITS'($urandom_range(0, 15));
				it.y = COORD_BITS'($urandom_range(0, 15));
			end else begin
				it.x = COORD_BITS'($urandom_range(0, COORD_SPAN - 1));
				it.y = COORD_BITS'($urandom_range(0, COORD_SPAN - 1));
			end
		end
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input pixel_item_t it, input logic typed,
		input site_result_t typed_res);
		site_result_t predicted;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid    = 1'b1;
		item_ch.kind     = it.kind;
		item_ch.pos_x    = it.x;
		item_ch.pos_y    = it.y;
		item_ch.red_in   = it.r;
		item_ch.green_in = it.g;
		item_ch.blue_in  = it.b;
		do @(posedge clk); while (!item_ch.ready);
		predicted = classify_and_update(it);
		nearest_queue.push_back(typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	task automatic write_raster(input logic [CFG_IDX_W-1:0] idx,
		input logic [REG_W-1:0] val);
		cfg_ch.valid     = 1'b1;
		cfg_ch.reg_index = idx;
		cfg_ch.wdata     = val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_RASTER_WIDTH) begin
			raster_w = val;
		end else if (idx == CFG_RASTER_HEIGHT) begin
			raster_h = val;
		end
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		item_ch.valid = 1'b0;
		while (nearest_queue.size() != 0) @(negedge clk);
	endtask

	always #4 clk = ~clk;

	always @(negedge clk) begin
		result_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (nearest_queue.size() == 0) begin
				$error("result transaction with nothing expected");
				error_count++;
			end else begin
				want = nearest_queue.pop_front();
				if (result_ch.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result_ch.status);
					error_count++;
				end
				if (result_ch.site_index !== want.idx) begin
					$error("site_index expected %0d actual %0d", want.idx,
						result_ch.site_index);
					error_count++;
				end
				if (result_ch.red_out !== want.r) begin
					$error("red_out expected %0h actual %0h", want.r, result_ch.red_out);
					error_count++;
				end
				if (result_ch.green_out !== want.g) begin
					$error("green_out expected %0h actual %0h", want.g, result_ch.green_out);
					error_count++;
				end
				if (result_ch.blue_out !== want.b) begin
					$error("blue_out expected %0h actual %0h", want.b, result_ch.blue_out);
					error_count++;
				end
			end
		end
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		item_ch.valid    = 1'b0;
		item_ch.kind     = KIND_ADD;
		item_ch.pos_x    = '0;
		item_ch.pos_y    = '0;
		item_ch.red_in   = '0;
		item_ch.green_in = '0;
		item_ch.blue_in  = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.reg_index = CFG_RASTER_WIDTH;
		cfg_ch.wdata     = '0;
		result_ch.ready  = 1'b0;
		src_idle_pct     = 37;
		sink_idle_pct    = 76;
		error_count      = 0;
		cycle_count      = 0;
		site_total       = 0;
		raster_w         = RESET_WIDTH;
		raster_h         = RESET_HEIGHT;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
		end
		wait_drained();

		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			case (seg / 2)
				0: begin
					src_idle_pct  = 37;
					sink_idle_pct = 76;
				end
				1: begin
					src_idle_pct  = 76;
					sink_idle_pct = 37;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			if (seg == SEG_RANDOM) begin
				write_raster(CFG_RASTER_WIDTH, REG_W'($urandom_range(1, COORD_SPAN)));
				write_raster(CFG_RASTER_HEIGHT, REG_W'($urandom_range(1, COORD_SPAN)));
			end else begin
				write_raster(CFG_RASTER_WIDTH, SEG_WIDTH[seg]);
				write_raster(CFG_RASTER_HEIGHT, SEG_HEIGHT[seg]);
			end
			// unmapped index must leave both raster registers alone
			if (seg == 2) begin
				write_raster(CFG_SPARE, REG_W'($urandom_range(1, 8191)));
			end
			for (int n = 0; n < SEG_ITEMS; n++) begin
				send_item(make_random_item(), 1'b0, '0);
			end
			wait_drained();
		end

		repeat (LATENCY + 16) @(negedge clk);
		if (nearest_queue.size() != 0) begin
			$error("%0d results never arrived", nearest_queue.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
